/* sv/twt_pkg.sv */
// ----------------------------------------------------------------------------
// twt_pkg
// Shared types and constants for the timer wheel table.
// ----------------------------------------------------------------------------
package twt_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int TIMER_COUNT = 32;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int ID_W        = 5;
  localparam int IDX_W       = $clog2(TIMER_COUNT);
  localparam int CNT_W       = $clog2(TIMER_COUNT + 1);
  localparam int TIME_W      = 32;
  // entry word: slot, deadline, stamp
  localparam int ENTRY_W     = SLOT_W + 2 * TIME_W;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SCAN,
    ST_EMIT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  // wheel order: slot, then deadline, newer stamp first, then lower id
  function automatic logic goes_before(entry_t a, logic [IDX_W-1:0] ia,
                                       entry_t b, logic [IDX_W-1:0] ib);
    logic r;
    if (a.slot != b.slot) r = a.slot < b.slot;
    else if (a.deadline != b.deadline) r = a.deadline < b.deadline;
    else if (a.stamp != b.stamp) r = a.stamp > b.stamp;
    else r = ia < ib;
    return r;
  endfunction

endpackage

/* sv/twt_ram.sv */
// ----------------------------------------------------------------------------
// twt_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module twt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* sv/timer_wheel_table_core.sv */
// ----------------------------------------------------------------------------
// timer_wheel_table_core
// Hashed timing wheel of timers with add, delete, modify and tick commands.
// ----------------------------------------------------------------------------
// Timer entries (slot, deadline, stamp) live in one single-port RAM; active
// flags are flip-flops cleared by reset. Add, delete and modify pass through
// a RAM read, an update and write, and a response before their result is
// registered. A tick sweeps the RAM once per reported timer, one entry a
// cycle, keeping the earliest expired entry in wheel order and counting how
// many are due, so the final report is flagged last. There are max(k,1)
// sweeps for k expired timers. Results sit in an output register; the next
// command is taken once it is transferred.
module timer_wheel_table_core
  import twt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic [ID_W-1:0]   in_timer_id,
  input  logic [TIME_W-1:0] in_deadline,
  input  logic [TIME_W-1:0] in_extension,
  input  logic [TIME_W-1:0] in_now_time,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_status,
  output logic              out_expired_valid,
  output logic [ID_W-1:0]   out_expired_id,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [TIME_W-1:0]      base_r;
  logic [TIME_W-1:0]      stamp_r;
  logic [TIMER_COUNT-1:0] active_r;

  // captured command
  cmd_t              cmd_r;
  logic [ID_W-1:0]   id_r;
  logic              id_ok_r;
  logic [TIME_W-1:0] dl_r, ext_r, now_r;

  // scan state
  logic [CNT_W-1:0]  scan_r;     // address issued
  logic              rd_vld_r;   // RAM data valid this cycle
  logic [IDX_W-1:0]  rd_idx_r;
  logic              found_r;
  logic [CNT_W-1:0]  cnt_r;      // due timers seen this sweep
  logic [IDX_W-1:0]  best_idx_r;
  entry_t            best_r;

  // output register
  logic              ov_r, os_r, oe_r, ol_r;
  logic [ID_W-1:0]   oid_r;
  logic              ov_load;

  // RAM port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  entry_t            ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;

  twt_ram #(.WIDTH(ENTRY_W), .DEPTH(TIMER_COUNT)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rbits)
  );
  assign ram_rdata = entry_t'(ram_rbits);

  logic id_ok;
  assign id_ok = {1'b0, in_timer_id} < (ID_W+1)'(TIMER_COUNT) ;

  // exec helpers for add/modify
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] new_dl;
  logic              id_act;
  logic              cand;
  logic              exec_ok;
  assign id_act = active_r[id_r[IDX_W-1:0]];
  assign sum    = {1'b0, ram_rdata.deadline} + {1'b0, ext_r};
  assign new_dl = (cmd_r == CMD_ADD) ? dl_r
                : (sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0]);
  assign cand   = rd_vld_r && active_r[rd_idx_r] && ram_rdata.deadline <= now_r;
  assign exec_ok = id_ok_r && ((cmd_r == CMD_ADD) ? (!id_act && new_dl >= base_r)
                 : (id_act && (cmd_r == CMD_DELETE || new_dl >= base_r)));
  assign ov_load = ((state_r == ST_EMIT) || (state_r == ST_RESP)) && (!ov_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && in_ready) begin
        state_nxt = (cmd_t'(in_command) == CMD_TICK) ? ST_SCAN : ST_READ;
      end
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_RESP;
      ST_SCAN: if (!rd_vld_r && scan_r == CNT_W'(TIMER_COUNT)) begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: if (!ov_r || out_ready) begin
        state_nxt = (found_r && cnt_r != CNT_W'(1)) ? ST_SCAN : ST_IDLE;
      end
      ST_RESP: if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the FSM
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = id_r[IDX_W-1:0];
    ram_wdata = '{slot: SLOT_W'(new_dl - base_r), deadline: new_dl, stamp: stamp_r};
    case (state_r)
      ST_SCAN: ram_addr = scan_r[IDX_W-1:0];
      ST_EXEC: ram_we = (cmd_r != CMD_DELETE) && exec_ok;
      default: ;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_status = os_r;
  assign out_expired_valid = oe_r;
  assign out_expired_id = oid_r;
  assign out_last = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      base_r   <= '0;
      stamp_r  <= '0;
      active_r <= '0;
      ov_r     <= 1'b0;
      rd_vld_r <= 1'b0;
      scan_r   <= '0;
      found_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) base_r <= cfg_wdata;
      if (ov_load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      rd_vld_r <= (state_r == ST_SCAN) && (scan_r != CNT_W'(TIMER_COUNT));
      case (state_r)
        ST_IDLE: if (in_valid && in_ready) begin
          cmd_r   <= cmd_t'(in_command);
          id_r    <= in_timer_id;
          id_ok_r <= id_ok;
          dl_r    <= in_deadline;
          ext_r   <= in_extension;
          now_r   <= in_now_time;
          scan_r  <= '0;
          found_r <= 1'b0;
          cnt_r   <= '0;
        end
        ST_EXEC: begin
          os_r <= !exec_ok;
          // add touches the flag only on success; delete/modify of an active timer
          if (id_ok_r && ((cmd_r == CMD_ADD) ? exec_ok : id_act)) begin
            active_r[id_r[IDX_W-1:0]] <= exec_ok && (cmd_r != CMD_DELETE);
          end
          if (ram_we) stamp_r <= stamp_r + TIME_W'(1);
        end
        ST_SCAN: begin
          if (scan_r != CNT_W'(TIMER_COUNT)) begin
            rd_idx_r <= scan_r[IDX_W-1:0];
            scan_r   <= scan_r + CNT_W'(1);
          end
          if (cand) cnt_r <= cnt_r + CNT_W'(1);
          if (cand && (!found_r ||
              goes_before(ram_rdata, rd_idx_r, best_r, best_idx_r))) begin
            found_r    <= 1'b1;
            best_r     <= ram_rdata;
            best_idx_r <= rd_idx_r;
          end
        end
        ST_EMIT: if (!ov_r || out_ready) begin
          os_r  <= 1'b0;
          if (found_r) begin
            // the report is final only when one timer was due in this sweep
            oe_r  <= 1'b1;
            oid_r <= ID_W'(best_idx_r);
            ol_r  <= (cnt_r == CNT_W'(1));
            active_r[best_idx_r] <= 1'b0;
          end else begin
            oe_r  <= 1'b0;
            oid_r <= '0;
            ol_r  <= 1'b1;
          end
          scan_r  <= '0;
          found_r <= 1'b0;
          cnt_r   <= '0;
        end
        ST_RESP: if (!ov_r || out_ready) begin
          oe_r  <= 1'b0;
          oid_r <= '0;
          ol_r  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // assertions
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("accepted while busy");
  a_ram_we_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_EXEC) else $error("RAM written outside update");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

/* dv/timer_wheel_table_checker.sv */
// ----------------------------------------------------------------------------
// timer_wheel_table_checker
// Watches the command, result and configuration ports of the timer wheel
// table, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module timer_wheel_table_checker
  import twt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic [ID_W-1:0]   in_timer_id,
  input  logic [TIME_W-1:0] in_deadline,
  input  logic [TIME_W-1:0] in_extension,
  input  logic [TIME_W-1:0] in_now_time,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_status,
  output int                mismatches,
  input  logic              out_expired_valid,
  input  logic [ID_W-1:0]   out_expired_id,
  input  logic              out_last,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            status;
    logic            expired_valid;
    logic [ID_W-1:0] expired_id;
    logic            last;
  } wheel_result_t;

  // predicted wheel contents
  logic [TIME_W-1:0] wheel_base;
  logic [TIME_W-1:0] tmr_deadline [TIMER_COUNT];
  logic              tmr_active   [TIMER_COUNT];
  logic [SLOT_W-1:0] tmr_slot     [TIMER_COUNT];
  logic [TIME_W-1:0] tmr_stamp    [TIMER_COUNT];
  logic [TIME_W-1:0] next_stamp;

  wheel_result_t due_results[$];

  function automatic bit arm_timer(int id, logic [TIME_W-1:0] dl);
    if (dl < wheel_base) return 0;
    tmr_deadline[id] = dl;
    tmr_slot[id]     = SLOT_W'((dl - wheel_base) % SLOT_COUNT);
    tmr_stamp[id]    = next_stamp;
    next_stamp       = next_stamp + 1;
    tmr_active[id]   = 1'b1;
    return 1;
  endfunction

  // wheel order: slot, deadline, newer stamp, lower id
  function automatic bit precedes(int a, int b);
    if (tmr_slot[a] != tmr_slot[b]) return tmr_slot[a] < tmr_slot[b];
    if (tmr_deadline[a] != tmr_deadline[b]) return tmr_deadline[a] < tmr_deadline[b];
    if (tmr_stamp[a] != tmr_stamp[b]) return tmr_stamp[a] > tmr_stamp[b];
    return a < b;
  endfunction

  function automatic void predict_command(cmd_t cmd, int id, logic [TIME_W-1:0] dl,
                                          logic [TIME_W-1:0] ext,
                                          logic [TIME_W-1:0] now);
    wheel_result_t r;
    int            best;
    int            fired;
    bit            ok;
    logic [TIME_W-1:0] nd;
    r = '0;
    ok = 0;
    fired = 0;
    if (cmd == CMD_TICK) begin
      forever begin
        best = -1;
        for (int i = 0; i < TIMER_COUNT; i++)
          if (tmr_active[i] && tmr_deadline[i] <= now)
            if (best < 0 || precedes(i, best)) best = i;
        if (best < 0) break;
        tmr_active[best] = 1'b0;
        r.expired_valid = 1'b1;
        r.expired_id    = ID_W'(best);
        due_results = {due_results, r};
        fired++;
      end
      if (fired == 0) begin
        r.last = 1'b1;
        due_results = {due_results, r};
      end else begin
        due_results[$].last = 1'b1;
      end
    end else begin
      if (id < TIMER_COUNT) begin
        if (cmd == CMD_ADD) begin
          if (!tmr_active[id]) ok = arm_timer(id, dl);
        end else if (tmr_active[id]) begin
          tmr_active[id] = 1'b0;
          if (cmd == CMD_DELETE) begin
            ok = 1;
          end else begin
            nd = tmr_deadline[id] + ext;
            if (nd < ext) nd = '1;  // saturate
            ok = arm_timer(id, nd);
          end
        end
      end
      r.status = !ok;
      r.last   = 1'b1;
      due_results = {due_results, r};
    end
  endfunction

  always @(posedge clk) begin
    wheel_result_t got, want;
    if (!rst_n) begin
      wheel_base = '0;
      next_stamp = '0;
      mismatches = 0;
      due_results.delete();
      for (int i = 0; i < TIMER_COUNT; i++) begin
        tmr_active[i]   = 1'b0;
        tmr_deadline[i] = '0;
        tmr_slot[i]     = '0;
        tmr_stamp[i]    = '0;
      end
    end else begin
      // result first: a result at this edge always belongs to an older command
      if (out_valid && out_ready) begin
        got = '{out_status, out_expired_valid, out_expired_id, out_last};
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        predict_command(cmd_t'(in_command), int'(in_timer_id), in_deadline,
                        in_extension, in_now_time);
      if (cfg_we) wheel_base = cfg_wdata;
    end
    pending = due_results.size();
  end

endmodule

/* dv/tb_timer_wheel_table_core.sv */
// ----------------------------------------------------------------------------
// tb_timer_wheel_table_core
// Stimulus and verdict for the timer wheel table core.
// ----------------------------------------------------------------------------
// Fills the wheel, runs a directed pass over the corner cases, then random
// command streams under several base times. A checker beside the block
// predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_timer_wheel_table_core;
  import twt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  cmd_t              in_command;
  logic [ID_W-1:0]   in_timer_id;
  logic [TIME_W-1:0] in_deadline;
  logic [TIME_W-1:0] in_extension;
  logic [TIME_W-1:0] in_now_time;
  logic              out_valid;
  logic              out_ready;
  logic              out_status;
  logic              out_expired_valid;
  logic [ID_W-1:0]   out_expired_id;
  logic              out_last;
  logic              cfg_we;
  logic [TIME_W-1:0] cfg_wdata;
  int                mismatches;
  int                pending;

  // stimulus-side view of time, relative to the current base
  logic [TIME_W-1:0] base_now;
  logic [TIME_W-1:0] clock_cursor;
  bit                no_gaps;

  timer_wheel_table_core dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_command, .in_timer_id, .in_deadline,
    .in_extension, .in_now_time,
    .out_valid, .out_ready, .out_status, .out_expired_valid,
    .out_expired_id, .out_last,
    .cfg_we, .cfg_wdata
  );

  timer_wheel_table_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_command, .in_timer_id, .in_deadline,
    .in_extension, .in_now_time,
    .out_valid, .out_ready, .out_status, .mismatches, .out_expired_valid,
    .out_expired_id, .out_last,
    .cfg_we, .cfg_wdata, .pending
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // one command transfer; valid stays up across back-to-back items
  task automatic issue(cmd_t cmd, int id, logic [TIME_W-1:0] dl,
                       logic [TIME_W-1:0] ext, logic [TIME_W-1:0] now);
    int gap;
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_timer_id  <= ID_W'(id);
    in_deadline  <= dl;
    in_extension <= ext;
    in_now_time  <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // base_time is only written with the wheel quiet
  task automatic set_base(logic [TIME_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    base_now     = value;
    clock_cursor = '0;
  endtask

  // random command mix centred on the current time so ticks do fire
  task automatic random_commands(int count);
    int r, id;
    logic [TIME_W-1:0] dl, ext, now;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r  = $urandom_range(0, 99);
      id = $urandom_range(0, TIMER_COUNT - 1);
      r  = $urandom_range(0, 99);
      if (r < 40) begin
        r = $urandom_range(0, 99);
        if (r < 85)      dl = base_now + clock_cursor + $urandom_range(0, 60);
        else if (r < 95) dl = $urandom;
        else             dl = base_now - 1 - $urandom_range(0, 20);  // early
        issue(CMD_ADD, id, dl, $urandom, $urandom);
      end else if (r < 55) begin
        issue(CMD_DELETE, id, $urandom, $urandom, $urandom);
      end else if (r < 72) begin
        ext = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
        issue(CMD_MODIFY, id, $urandom, ext, $urandom);
      end else begin
        clock_cursor = clock_cursor + $urandom_range(0, 30);
        now = ($urandom_range(0, 19) == 0) ? $urandom : base_now + clock_cursor;
        issue(CMD_TICK, id, $urandom, $urandom, now);
      end
    end
  endtask

  // result side: random back-pressure, plus one long hold-off so the
  // block fills and stalls its command input
  initial begin
    int gap;
    int rounds;
    out_ready = 1'b0;
    rounds = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      rounds++;
      if (rounds == 120) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // stimulus
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_command   = CMD_ADD;
    in_timer_id  = '0;
    in_deadline  = '0;
    in_extension = '0;
    in_now_time  = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    base_now     = '0;
    clock_cursor = '0;
    no_gaps      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every entry before anything can read one: all land in slot 5,
    // three deadline groups, so equal keys fall back on stamp order
    for (int i = 0; i < TIMER_COUNT; i++)
      issue(CMD_ADD, i, 5 + 16 * (i % 3), '0, '0);

    // directed corners
    issue(CMD_TICK, 0, '0, '0, 32'd21);         // equal deadlines, stamp order
    issue(CMD_TICK, 0, '0, '0, '0);             // nothing due
    issue(CMD_ADD, 0, '0, '0, '0);              // lowest deadline
    issue(CMD_ADD, 0, 32'd9, '0, '0);           // duplicate add
    issue(CMD_DELETE, 3, '0, '0, '0);           // already expired
    issue(CMD_MODIFY, 4, '0, '0, '0);           // already expired
    issue(CMD_MODIFY, 2, '0, 32'd10, '0);
    issue(CMD_MODIFY, 5, '0, '1, '0);           // sum saturates
    issue(CMD_DELETE, 8, '0, '0, '0);
    issue(CMD_ADD, 3, '1, '1, '1);              // highest deadline
    set_base(32'd100);
    issue(CMD_ADD, 6, 32'd99, '0, '0);          // early deadline
    issue(CMD_MODIFY, 11, '0, '0, '0);          // re-add falls below base
    issue(CMD_ADD, 6, 32'd100, '0, '0);         // slot reckoned from the new base
    issue(CMD_TICK, 31, '1, '1, '1);            // everything expires
    issue(CMD_TICK, 31, '1, '1, '1);

    set_base('0);
    random_commands(150);
    set_base($urandom);
    random_commands(110);
    set_base(32'hFFFF_FF00);
    random_commands(90);
    set_base('1);
    issue(CMD_ADD, 7, '1, '0, '0);
    random_commands(25);
    set_base($urandom);
    random_commands(40);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop well beyond the slowest legitimate run
  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
sv/twt_pkg.sv
sv/twt_ram.sv
sv/timer_wheel_table_core.sv
dv/timer_wheel_table_checker.sv
dv/tb_timer_wheel_table_core.sv
